/* rtl/msem_pkg.sv */
// Shared constants, codes and control types for the mailbox and semaphore table.
`default_nettype none
package msem_pkg;

  // Pool geometry
  localparam int SLOTS    = 64;
  localparam int SEM_BASE = 32;
  localparam int SEM_LAST = 63;
  localparam int ADDR_W   = $clog2(SLOTS);

  // Width for signed position arithmetic (index plus semaphore offset)
  localparam int POS_W = 12;

  localparam logic signed [POS_W-1:0] SLOTS_S    = POS_W'(SLOTS);
  localparam logic signed [POS_W-1:0] SEM_BASE_S = POS_W'(SEM_BASE);
  localparam logic signed [POS_W-1:0] SEM_LAST_S = POS_W'(SEM_LAST);

  localparam logic signed [31:0] COUNT_MAX = 32'sh7fff_ffff;

  // Request actions
  localparam logic [2:0] ACT_SEND = 3'd0;
  localparam logic [2:0] ACT_GET  = 3'd1;
  localparam logic [2:0] ACT_INIT = 3'd2;
  localparam logic [2:0] ACT_P    = 3'd3;
  localparam logic [2:0] ACT_V    = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture a new request
    logic exec;      // evaluate the request and emit its result
    logic wr_allow;  // slot update permitted this cycle
  } msem_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic range_err; // captured request has a bad index or action
  } msem_sts_t;

endpackage
`default_nettype wire

/* rtl/msem_ctrl.sv */
// Controller state machine sequencing load, slot read and execute phases.
`default_nettype none
module msem_ctrl
  import msem_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire msem_sts_t sts,
  output msem_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EX   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Advance through the three phases of a request
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_RD;
      S_RD:   state_nxt = S_EX;
      S_EX:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive datapath commands; block slot writes on a bad request
  always_comb begin
    busy         = (state_r != S_IDLE);
    cmd.load     = (state_r == S_IDLE) && start;
    cmd.exec     = (state_r == S_EX);
    cmd.wr_allow = (state_r == S_EX) && !sts.range_err;
  end

endmodule
`default_nettype wire

/* rtl/msem_dp.sv */
// Datapath: request registers, slot memory with valid bits, result registers.
`default_nettype none
module msem_dp
  import msem_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic        [2:0]  in_action,
  input  wire logic signed [7:0]  in_index,
  input  wire logic signed [31:0] in_value,
  input  wire msem_cmd_t          cmd,
  output msem_sts_t               sts,
  output logic                    out_valid,
  output logic             [1:0]  out_status,
  output logic signed      [31:0] out_read_word
);

  // Slot memory: {word, count} per entry
  logic [63:0] mem [SLOTS];
  logic [SLOTS-1:0] vld_r;

  // Captured request
  logic        [2:0]        action_r;
  logic signed [31:0]       value_r;
  logic        [ADDR_W-1:0] addr_r;
  logic                     range_err_r;

  // Registered slot read
  logic [63:0] rd_data_r;
  logic        rd_vld_r;

  // Result registers
  logic              out_valid_r;
  logic        [1:0] out_status_r;
  logic signed [31:0] out_word_r;

  // Decode index and range at capture time
  logic signed [POS_W-1:0] idx_x;
  logic signed [POS_W-1:0] pos_x;
  logic                    mbox_ok;
  logic                    sem_ok;
  logic                    is_sem;
  logic                    req_err;
  logic [ADDR_W-1:0]       addr_nxt;

  always_comb begin
    idx_x   = POS_W'(in_index);
    pos_x   = idx_x + SEM_BASE_S;
    mbox_ok = (idx_x >= 0) && (idx_x < SLOTS_S);
    sem_ok  = (pos_x >= SEM_BASE_S) && (pos_x <= SEM_LAST_S) &&
              (pos_x >= 0) && (pos_x < SLOTS_S);
    is_sem  = (in_action == ACT_INIT) || (in_action == ACT_P) || (in_action == ACT_V);
    priority if ((in_action == ACT_SEND) || (in_action == ACT_GET)) begin
      req_err  = !mbox_ok;
      addr_nxt = idx_x[ADDR_W-1:0];
    end else if (is_sem) begin
      req_err  = !sem_ok;
      addr_nxt = pos_x[ADDR_W-1:0];
    end else begin
      req_err  = 1'b1;
      addr_nxt = idx_x[ADDR_W-1:0];
    end
  end

  // Hold the request while it is worked on
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r    <= in_action;
      value_r     <= in_value;
      addr_r      <= addr_nxt;
      range_err_r <= req_err;
    end
  end

  assign sts.range_err = range_err_r;

  // Read the addressed slot in the cycle after capture
  always_ff @(posedge clk) begin
    rd_data_r <= mem[addr_r];
    rd_vld_r  <= vld_r[addr_r];
  end

  // Evaluate the operation against the current slot contents
  logic signed [31:0] cur_word;
  logic signed [31:0] cur_count;
  logic signed [31:0] new_word;
  logic signed [31:0] new_count;
  logic               need_wr;
  logic        [1:0]  res_status;
  logic signed [31:0] res_word;

  always_comb begin
    cur_word   = rd_vld_r ? $signed(rd_data_r[63:32]) : 32'sd0;
    cur_count  = rd_vld_r ? $signed(rd_data_r[31:0])  : 32'sd0;
    new_word   = cur_word;
    new_count  = cur_count;
    need_wr    = 1'b0;
    res_status = ST_OK;
    res_word   = 32'sd0;
    if (range_err_r) begin
      res_status = ST_RANGE;
    end else begin
      unique case (action_r)
        ACT_SEND: begin
          new_word  = value_r;
          new_count = 32'sd1;
          need_wr   = 1'b1;
        end
        ACT_GET: begin
          if (cur_count == 32'sd0) begin
            res_status = ST_EMPTY;
          end else begin
            res_word  = cur_word;
            new_word  = 32'sd0;
            new_count = 32'sd0;
            need_wr   = 1'b1;
          end
        end
        ACT_INIT: begin
          new_count = value_r;
          need_wr   = 1'b1;
        end
        ACT_P: begin
          if (cur_count <= 32'sd0) begin
            res_status = ST_EMPTY;
          end else begin
            new_count = cur_count - 32'sd1;
            need_wr   = 1'b1;
          end
        end
        ACT_V: begin
          if (cur_count != COUNT_MAX) begin
            new_count = cur_count + 32'sd1;
            need_wr   = 1'b1;
          end
        end
        default: begin
          res_status = ST_RANGE;
        end
      endcase
    end
  end

  // Update the slot memory
  always_ff @(posedge clk) begin
    if (cmd.wr_allow && need_wr) begin
      mem[addr_r] <= {new_word, new_count};
    end
  end

  // Mark written slots valid; unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr_allow && need_wr) begin
      vld_r[addr_r] <= 1'b1;
    end
  end

  // Register the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= res_status;
      out_word_r   <= res_word;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_word = out_word_r;

endmodule
`default_nettype wire

/* rtl/mailbox_semaphore_table_core.sv */
// Top level of the mailbox and semaphore table: controller plus datapath.
//
// Usage:
//   Request channel: drive in_action, in_index and in_value and raise start.
//   A request is taken at a rising edge where start is high and busy is low.
//   Result channel: out_valid is high for exactly one cycle carrying
//   out_status and out_read_word; the receiver cannot stall it.
// Timing:
//   A request taken at a rising edge first has its slot read registered, then
//   is evaluated and its result registered; out_valid goes high after the
//   result register is loaded. busy stays high through the slot read and
//   execute states, so a new request is taken only once the last one is done;
//   this is set by the single read-then-write access to the slot memory (registered read port).
// Reset:
//   rst_n low clears the controller, the result strobe and the slot valid
//   bits; every slot then reads as word zero and count zero. No clearing
//   pass is needed, so requests are taken right after reset.
`default_nettype none
module mailbox_semaphore_table_core
  import msem_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [2:0]  in_action,
  input  wire logic signed [7:0]  in_index,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  output logic             [1:0]  out_status,
  output logic signed      [31:0] out_read_word
);

  msem_cmd_t cmd;
  msem_sts_t sts;

  // Sequence each request
  msem_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Hold slots and compute results
  msem_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_action),
    .in_index      (in_index),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_read_word (out_read_word)
  );

endmodule
`default_nettype wire
